@@ hw/rtl/pcrs_pkg.sv @@
// Package for the periodic chirp reminder sequencer.
// Holds widths, register reset values, codes and the structs shared by all modules.
// No dependencies.
`timescale 1ns / 1ps

package pcrs_pkg;

   // Counter widths
   localparam int TIME_BITS  = 24;
   localparam int COUNT_BITS = 8;

   // Fixed field widths of the register bank
   localparam int CSR_TIME_W   = 24;
   localparam int CSR_COUNT_W  = 8;
   localparam int CSR_CHIRP_W  = 16;
   localparam int CSR_DATA_W   = 24;
   localparam int CSR_INDEX_W  = 3;

   // Width used for unsigned compares between counters and register fields
   localparam int CMP_W = 33;

   // Register reset values
   localparam logic [CSR_TIME_W-1:0]  RST_INTERVAL   = CSR_TIME_W'(900000);
   localparam logic [CSR_COUNT_W-1:0] RST_OCC_SHORT  = CSR_COUNT_W'(1);
   localparam logic [CSR_COUNT_W-1:0] RST_OCC_LONG   = CSR_COUNT_W'(8);
   localparam logic [CSR_TIME_W-1:0]  RST_CHIRP_WIN  = CSR_TIME_W'(30000);
   localparam logic [CSR_CHIRP_W-1:0] RST_CHIRP_PER  = CSR_CHIRP_W'(1000);
   localparam logic [CSR_CHIRP_W-1:0] RST_CHIRP_ON   = CSR_CHIRP_W'(200);
   localparam logic [CSR_TIME_W-1:0]  RST_DISMISS_WIN = CSR_TIME_W'(300000);

   // Register indexes
   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_INTERVAL    = 3'd0,
      CSR_OCC_SHORT   = 3'd1,
      CSR_OCC_LONG    = 3'd2,
      CSR_CHIRP_WIN   = 3'd3,
      CSR_CHIRP_PER   = 3'd4,
      CSR_CHIRP_ON    = 3'd5,
      CSR_DISMISS_WIN = 3'd6,
      CSR_ACTIVE_LOW  = 3'd7
   } csr_index_type;

   // Input word kinds
   typedef enum logic [1:0] {
      KIND_START   = 2'd0,
      KIND_CANCEL  = 2'd1,
      KIND_DISMISS = 2'd2,
      KIND_TICK    = 2'd3
   } kind_type;

   // Start modes
   localparam logic [1:0] MODE_SHORT = 2'd1;
   localparam logic [1:0] MODE_LONG  = 2'd2;

   // Sequencer phase
   typedef enum logic [1:0] {
      PH_IDLE  = 2'd0,
      PH_WAIT  = 2'd1,
      PH_CHIRP = 2'd2
   } phase_type;

   // Register bank contents
   typedef struct packed {
      logic [CSR_TIME_W-1:0]  interval_ms;
      logic [CSR_COUNT_W-1:0] occurrences_short;
      logic [CSR_COUNT_W-1:0] occurrences_long;
      logic [CSR_TIME_W-1:0]  chirp_window_ms;
      logic [CSR_CHIRP_W-1:0] chirp_period_ms;
      logic [CSR_CHIRP_W-1:0] chirp_on_ms;
      logic [CSR_TIME_W-1:0]  dismiss_window_ms;
      logic                   pin_invert;
   } cfg_type;

   // One result word
   typedef struct packed {
      logic      buzzer_pin;
      logic      sequence_active;
      logic      window_open;
      logic      dismiss_accepted;
      phase_type phase;
   } rsp_type;

endpackage

@@ hw/rtl/pcrs_csr.sv @@
// Configuration register bank of the chirp reminder sequencer.
// Depends on pcrs_pkg for field widths, reset values and register indexes.
`timescale 1ns / 1ps

module pcrs_csr (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_we,
   input  logic [pcrs_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [pcrs_pkg::CSR_DATA_W-1:0]  csr_wdata,
   output pcrs_pkg::cfg_type                cfg
);

   pcrs_pkg::cfg_type cfg_ff;
   pcrs_pkg::cfg_type cfg_in;

   // Field update on a write, truncated to the field width
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (pcrs_pkg::csr_index_type'(csr_index))
            pcrs_pkg::CSR_INTERVAL:
               cfg_in.interval_ms = csr_wdata[pcrs_pkg::CSR_TIME_W-1:0];
            pcrs_pkg::CSR_OCC_SHORT:
               cfg_in.occurrences_short = csr_wdata[pcrs_pkg::CSR_COUNT_W-1:0];
            pcrs_pkg::CSR_OCC_LONG:
               cfg_in.occurrences_long = csr_wdata[pcrs_pkg::CSR_COUNT_W-1:0];
            pcrs_pkg::CSR_CHIRP_WIN:
               cfg_in.chirp_window_ms = csr_wdata[pcrs_pkg::CSR_TIME_W-1:0];
            pcrs_pkg::CSR_CHIRP_PER:
               cfg_in.chirp_period_ms = csr_wdata[pcrs_pkg::CSR_CHIRP_W-1:0];
            pcrs_pkg::CSR_CHIRP_ON:
               cfg_in.chirp_on_ms = csr_wdata[pcrs_pkg::CSR_CHIRP_W-1:0];
            pcrs_pkg::CSR_DISMISS_WIN:
               cfg_in.dismiss_window_ms = csr_wdata[pcrs_pkg::CSR_TIME_W-1:0];
            pcrs_pkg::CSR_ACTIVE_LOW:
               cfg_in.pin_invert = csr_wdata[0];
            default: ;
         endcase
      end
   end

   // Register bank
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.interval_ms       <= pcrs_pkg::RST_INTERVAL;
         cfg_ff.occurrences_short <= pcrs_pkg::RST_OCC_SHORT;
         cfg_ff.occurrences_long  <= pcrs_pkg::RST_OCC_LONG;
         cfg_ff.chirp_window_ms   <= pcrs_pkg::RST_CHIRP_WIN;
         cfg_ff.chirp_period_ms   <= pcrs_pkg::RST_CHIRP_PER;
         cfg_ff.chirp_on_ms       <= pcrs_pkg::RST_CHIRP_ON;
         cfg_ff.dismiss_window_ms <= pcrs_pkg::RST_DISMISS_WIN;
         cfg_ff.pin_invert        <= 1'b0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

@@ hw/rtl/pcrs_core.sv @@
// Sequencer state and per-word update logic of the chirp reminder sequencer.
// Depends on pcrs_pkg for the phase enum, word kinds, cfg_type and rsp_type.
`timescale 1ns / 1ps

module pcrs_core (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_accept,
   input  logic [1:0]           req_kind,
   input  logic [1:0]           req_mode,
   input  pcrs_pkg::cfg_type    cfg,
   output pcrs_pkg::rsp_type    rsp
);

   localparam int TB = pcrs_pkg::TIME_BITS;
   localparam int CB = pcrs_pkg::COUNT_BITS;
   localparam int CW = pcrs_pkg::CMP_W;
   localparam int HW = pcrs_pkg::CSR_CHIRP_W;

   pcrs_pkg::phase_type phase_ff, phase_in;
   logic [TB-1:0] due_ff, due_in;
   logic [TB-1:0] elapsed_ff, elapsed_in;
   logic [HW-1:0] toggle_ff, toggle_in;
   logic [CB-1:0] idx_ff, idx_in;
   logic [CB-1:0] total_ff, total_in;
   logic          pre_ff, pre_in;
   logic          tone_ff, tone_in;
   logic          accepted;

   // Next state for one accepted word
   always_comb begin : next_state
      logic [CB-1:0] adv_idx;
      logic          adv_end;
      logic [TB-1:0] due_dec;
      logic [TB-1:0] elapsed_inc;
      logic [HW-1:0] toggle_inc;
      logic [HW-1:0] off_ms;

      phase_in   = phase_ff;
      due_in     = due_ff;
      elapsed_in = elapsed_ff;
      toggle_in  = toggle_ff;
      idx_in     = idx_ff;
      total_in   = total_ff;
      pre_in     = pre_ff;
      tone_in    = tone_ff;
      accepted   = 1'b0;

      adv_idx     = idx_ff + CB'(1);
      adv_end     = (adv_idx == '0) || (adv_idx >= total_ff);
      due_dec     = (due_ff != '0) ? due_ff - TB'(1) : due_ff;
      elapsed_inc = (elapsed_ff != '1) ? elapsed_ff + TB'(1) : elapsed_ff;
      toggle_inc  = (toggle_ff != '1) ? toggle_ff + HW'(1) : toggle_ff;
      off_ms      = cfg.chirp_period_ms - cfg.chirp_on_ms;

      if (req_accept) begin
         case (pcrs_pkg::kind_type'(req_kind))
            pcrs_pkg::KIND_START: begin
               if (req_mode == pcrs_pkg::MODE_SHORT || req_mode == pcrs_pkg::MODE_LONG) begin
                  total_in = (req_mode == pcrs_pkg::MODE_LONG) ?
                             CB'(cfg.occurrences_long) : CB'(cfg.occurrences_short);
                  phase_in = pcrs_pkg::PH_WAIT;
                  due_in   = TB'(cfg.interval_ms);
                  idx_in   = '0;
                  pre_in   = 1'b0;
                  tone_in  = 1'b0;
               end
            end
            pcrs_pkg::KIND_CANCEL: begin
               tone_in  = 1'b0;
               phase_in = pcrs_pkg::PH_IDLE;
            end
            pcrs_pkg::KIND_DISMISS: begin
               if (phase_ff == pcrs_pkg::PH_CHIRP) begin
                  // dismiss ends the current chirp at once
                  accepted = 1'b1;
                  tone_in  = 1'b0;
                  idx_in   = adv_idx;
                  if (adv_end) begin
                     phase_in = pcrs_pkg::PH_IDLE;
                  end else begin
                     phase_in = pcrs_pkg::PH_WAIT;
                     pre_in   = 1'b0;
                  end
               end else if (phase_ff == pcrs_pkg::PH_WAIT &&
                            CW'(due_ff) <= CW'(cfg.dismiss_window_ms)) begin
                  // pre-dismissal; on the last occurrence it ends the sequence
                  accepted = 1'b1;
                  if ((CB+1)'(idx_ff) + (CB+1)'(1) >= (CB+1)'(total_ff)) begin
                     phase_in = pcrs_pkg::PH_IDLE;
                  end else begin
                     pre_in = 1'b1;
                  end
               end
            end
            pcrs_pkg::KIND_TICK: begin
               if (phase_ff == pcrs_pkg::PH_WAIT) begin
                  due_in = due_dec;
                  if (due_dec == '0) begin
                     due_in = TB'(cfg.interval_ms);
                     if (pre_ff) begin
                        // skipped occurrence
                        idx_in = adv_idx;
                        if (adv_end) begin
                           phase_in = pcrs_pkg::PH_IDLE;
                        end else begin
                           phase_in = pcrs_pkg::PH_WAIT;
                           pre_in   = 1'b0;
                        end
                     end else begin
                        phase_in   = pcrs_pkg::PH_CHIRP;
                        elapsed_in = '0;
                        toggle_in  = '0;
                        tone_in    = 1'b0;
                     end
                  end
               end else if (phase_ff == pcrs_pkg::PH_CHIRP) begin
                  due_in     = due_dec;
                  elapsed_in = elapsed_inc;
                  toggle_in  = toggle_inc;
                  if (CW'(elapsed_inc) >= CW'(cfg.chirp_window_ms)) begin
                     // chirp window over
                     tone_in = 1'b0;
                     idx_in  = adv_idx;
                     if (adv_end) begin
                        phase_in = pcrs_pkg::PH_IDLE;
                     end else begin
                        phase_in = pcrs_pkg::PH_WAIT;
                        pre_in   = 1'b0;
                     end
                  end else if (!tone_ff) begin
                     if (cfg.chirp_on_ms <= cfg.chirp_period_ms && toggle_inc >= off_ms) begin
                        tone_in   = 1'b1;
                        toggle_in = '0;
                     end
                  end else if (toggle_inc >= cfg.chirp_on_ms) begin
                     tone_in   = 1'b0;
                     toggle_in = '0;
                  end
               end
            end
            default: ;
         endcase
      end
   end

   // Result word from the state after the word
   always_comb begin : result
      rsp.buzzer_pin       = tone_in ^ cfg.pin_invert;
      rsp.sequence_active  = (phase_in != pcrs_pkg::PH_IDLE);
      rsp.window_open      = (phase_in == pcrs_pkg::PH_CHIRP) ||
                             (phase_in == pcrs_pkg::PH_WAIT && !pre_in &&
                              CW'(due_in) <= CW'(cfg.dismiss_window_ms));
      rsp.dismiss_accepted = accepted;
      rsp.phase            = phase_in;
   end

   // State registers
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= pcrs_pkg::PH_IDLE;
         due_ff     <= '0;
         elapsed_ff <= '0;
         toggle_ff  <= '0;
         idx_ff     <= '0;
         total_ff   <= '0;
         pre_ff     <= 1'b0;
         tone_ff    <= 1'b0;
      end else begin
         phase_ff   <= phase_in;
         due_ff     <= due_in;
         elapsed_ff <= elapsed_in;
         toggle_ff  <= toggle_in;
         idx_ff     <= idx_in;
         total_ff   <= total_in;
         pre_ff     <= pre_in;
         tone_ff    <= tone_in;
      end
   end

`ifndef SYNTHESIS
   // tone only sounds while chirping
   a_tone_only_chirp: assert property (@(posedge clock) disable iff (reset)
      tone_ff |-> phase_ff == pcrs_pkg::PH_CHIRP)
      else $error("tone on outside chirp phase");

   // a pre-dismissed occurrence never starts chirping
   a_no_pre_in_chirp: assert property (@(posedge clock) disable iff (reset)
      phase_ff == pcrs_pkg::PH_CHIRP |-> !pre_ff)
      else $error("pre-dismiss flag set while chirping");

   // a fresh chirp starts with cleared counters
   a_chirp_entry: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == pcrs_pkg::PH_WAIT && phase_in == pcrs_pkg::PH_CHIRP) |=>
      (elapsed_ff == '0 && toggle_ff == '0 && !tone_ff))
      else $error("chirp entered with stale counters");
`endif

endmodule

@@ hw/rtl/periodic_chirp_reminder_sequencer.sv @@
// Top level of the periodic chirp reminder sequencer: handshake and result register.
// Depends on pcrs_pkg, pcrs_csr and pcrs_core.
//
//   channel | direction | handshake            | words
//   req_    | in        | req_valid/req_ready  | kind, mode
//   rsp_    | out       | rsp_valid/rsp_ready  | buzzer_pin, sequence_active, window_open,
//           |           |                      | dismiss_accepted, phase
//   csr_    | in        | csr_we               | csr_index, csr_wdata
//
// One word per cycle unless rsp_ stalls: the state update is one pass through
// pcrs_core, and the result lands in the output register on the edge that accepts
// the word. rsp_valid is registered and rises in the cycle after acceptance.
// req_ready is high while the output register is empty or being emptied, so a
// stalled rsp_ channel stalls req_ after one held result.
// Synchronous reset restores register defaults and the idle phase.
`timescale 1ns / 1ps

module periodic_chirp_reminder_sequencer (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic [1:0]                       req_kind,
   input  logic [1:0]                       req_mode,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic                             rsp_buzzer_pin,
   output logic                             rsp_sequence_active,
   output logic                             rsp_window_open,
   output logic                             rsp_dismiss_accepted,
   output logic [1:0]                       rsp_phase,
   input  logic                             csr_we,
   input  logic [pcrs_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [pcrs_pkg::CSR_DATA_W-1:0]  csr_wdata
);

   pcrs_pkg::cfg_type cfg;
   pcrs_pkg::rsp_type rsp_next;
   pcrs_pkg::rsp_type rsp_ff;
   logic              rsp_valid_ff, rsp_valid_in;
   logic              req_accept;

   // Handshake
   assign req_ready    = !rsp_valid_ff || rsp_ready;
   assign req_accept   = req_valid && req_ready;
   assign rsp_valid_in = req_accept || (rsp_valid_ff && !rsp_ready);

   pcrs_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   pcrs_core u_core (
      .clock      (clock),
      .reset      (reset),
      .req_accept (req_accept),
      .req_kind   (req_kind),
      .req_mode   (req_mode),
      .cfg        (cfg),
      .rsp        (rsp_next)
   );

   // Output valid
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Output word register
   always_ff @(posedge clock) begin
      if (req_accept) begin
         rsp_ff <= rsp_next;
      end
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_buzzer_pin       = rsp_ff.buzzer_pin;
   assign rsp_sequence_active  = rsp_ff.sequence_active;
   assign rsp_window_open      = rsp_ff.window_open;
   assign rsp_dismiss_accepted = rsp_ff.dismiss_accepted;
   assign rsp_phase            = rsp_ff.phase;

`ifndef SYNTHESIS
   // every accepted word yields a held result on the next cycle
   a_accept_gives_rsp: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> rsp_valid_ff)
      else $error("accepted word produced no result");

   // a dismiss is only reported on a dismiss word
   a_dismiss_kind: assert property (@(posedge clock) disable iff (reset)
      (req_accept && rsp_next.dismiss_accepted) |->
      req_kind == pcrs_pkg::KIND_DISMISS)
      else $error("dismiss reported on another word kind");

   // activity flag agrees with the phase
   a_active_phase: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_ff.sequence_active == (rsp_ff.phase != pcrs_pkg::PH_IDLE)))
      else $error("sequence_active disagrees with phase");
`endif

endmodule

@@ sim/periodic_chirp_reminder_sequencer_test.sv @@
// Self-checking testbench for periodic_chirp_reminder_sequencer.
// Drives req_/csr_ words, predicts every status word in-line, checks rsp_ words in order.
// Depends on pcrs_pkg and the sequencer RTL only.
`timescale 1ns / 1ps

module periodic_chirp_reminder_sequencer_test;

   // Start modes that the sequencer ignores
   localparam logic [1:0] MODE_OFF    = 2'd0;
   localparam logic [1:0] MODE_SPARE  = 2'd3;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                             req_valid = 1'b0;
   logic                             req_ready;
   logic [1:0]                       req_kind  = pcrs_pkg::KIND_TICK;
   logic [1:0]                       req_mode  = MODE_OFF;
   logic                             rsp_valid;
   logic                             rsp_ready = 1'b0;
   logic                             rsp_buzzer_pin;
   logic                             rsp_sequence_active;
   logic                             rsp_window_open;
   logic                             rsp_dismiss_accepted;
   logic [1:0]                       rsp_phase;
   logic                             csr_we    = 1'b0;
   logic [pcrs_pkg::CSR_INDEX_W-1:0] csr_index = pcrs_pkg::CSR_INTERVAL;
   logic [pcrs_pkg::CSR_DATA_W-1:0]  csr_wdata = '0;

   // Shared run control
   logic quiet    = 1'b0;   // no idling on either side
   int   hold_off = 0;      // one long receiver stall, in cycles
   int   mismatches = 0;

   // Predicted status words, oldest first
   pcrs_pkg::rsp_type pending_status[$];

   // Predictor copy of the register bank and sequencer state
   pcrs_pkg::cfg_type   regs = '{pcrs_pkg::RST_INTERVAL, pcrs_pkg::RST_OCC_SHORT,
                                 pcrs_pkg::RST_OCC_LONG, pcrs_pkg::RST_CHIRP_WIN,
                                 pcrs_pkg::RST_CHIRP_PER, pcrs_pkg::RST_CHIRP_ON,
                                 pcrs_pkg::RST_DISMISS_WIN, 1'b0};
   pcrs_pkg::phase_type seq_phase  = pcrs_pkg::PH_IDLE;
   logic [23:0]         due_ms     = '0;
   logic [7:0]          occ_index  = '0;
   logic [7:0]          occ_total  = '0;
   logic                skip_next  = 1'b0;
   logic [23:0]         chirp_ms   = '0;
   logic [15:0]         toggle_ms  = '0;
   logic                tone       = 1'b0;

   periodic_chirp_reminder_sequencer uut (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_ready            (req_ready),
      .req_kind             (req_kind),
      .req_mode             (req_mode),
      .rsp_valid            (rsp_valid),
      .rsp_ready            (rsp_ready),
      .rsp_buzzer_pin       (rsp_buzzer_pin),
      .rsp_sequence_active  (rsp_sequence_active),
      .rsp_window_open      (rsp_window_open),
      .rsp_dismiss_accepted (rsp_dismiss_accepted),
      .rsp_phase            (rsp_phase),
      .csr_we               (csr_we),
      .csr_index            (csr_index),
      .csr_wdata            (csr_wdata)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // ---------------------------------------------------------------- predictor

   // Move on to the next occurrence, or finish the sequence
   function automatic void advance_occurrence();
      occ_index = occ_index + 8'd1;
      if (occ_index == 8'd0 || occ_index >= occ_total) begin
         seq_phase = pcrs_pkg::PH_IDLE;
      end else begin
         seq_phase = pcrs_pkg::PH_WAIT;
         skip_next = 1'b0;
      end
   endfunction

   function automatic void apply_tick();
      if (seq_phase == pcrs_pkg::PH_IDLE) return;
      if (due_ms != 24'd0) due_ms = due_ms - 24'd1;
      if (seq_phase == pcrs_pkg::PH_WAIT) begin
         if (due_ms != 24'd0) return;
         due_ms = regs.interval_ms;
         if (skip_next) begin
            advance_occurrence();
            return;
         end
         seq_phase = pcrs_pkg::PH_CHIRP;
         chirp_ms  = '0;
         toggle_ms = '0;
         tone      = 1'b0;
         return;
      end
      // chirping: both counters saturate
      if (chirp_ms != '1) chirp_ms = chirp_ms + 24'd1;
      if (toggle_ms != '1) toggle_ms = toggle_ms + 16'd1;
      if (chirp_ms >= regs.chirp_window_ms) begin
         tone = 1'b0;
         advance_occurrence();
         return;
      end
      if (!tone) begin
         // on time above period: off time never runs out
         if (regs.chirp_on_ms <= regs.chirp_period_ms &&
             toggle_ms >= regs.chirp_period_ms - regs.chirp_on_ms) begin
            tone      = 1'b1;
            toggle_ms = '0;
         end
      end else if (toggle_ms >= regs.chirp_on_ms) begin
         tone      = 1'b0;
         toggle_ms = '0;
      end
   endfunction

   function automatic logic apply_dismiss();
      if (seq_phase == pcrs_pkg::PH_CHIRP) begin
         tone = 1'b0;
         advance_occurrence();
         return 1'b1;
      end
      if (seq_phase != pcrs_pkg::PH_WAIT) return 1'b0;
      if (due_ms > regs.dismiss_window_ms) return 1'b0;
      // pre-dismissing the last occurrence ends the sequence
      if (32'(occ_index) + 32'd1 >= 32'(occ_total)) seq_phase = pcrs_pkg::PH_IDLE;
      else skip_next = 1'b1;
      return 1'b1;
   endfunction

   // Update the state for one accepted word and return the status it yields
   function automatic pcrs_pkg::rsp_type predict_status(pcrs_pkg::kind_type kind,
                                                        logic [1:0] mode);
      pcrs_pkg::rsp_type st;
      logic              accepted;
      accepted = 1'b0;
      case (kind)
         pcrs_pkg::KIND_START: begin
            if (mode == pcrs_pkg::MODE_SHORT || mode == pcrs_pkg::MODE_LONG) begin
               occ_total = (mode == pcrs_pkg::MODE_LONG) ? regs.occurrences_long
                                                         : regs.occurrences_short;
               seq_phase = pcrs_pkg::PH_WAIT;
               due_ms    = regs.interval_ms;
               occ_index = '0;
               skip_next = 1'b0;
               tone      = 1'b0;
            end
         end
         pcrs_pkg::KIND_CANCEL: begin
            tone      = 1'b0;
            seq_phase = pcrs_pkg::PH_IDLE;
         end
         pcrs_pkg::KIND_DISMISS: accepted = apply_dismiss();
         default: apply_tick();
      endcase
      st.buzzer_pin       = tone ^ regs.pin_invert;
      st.sequence_active  = (seq_phase != pcrs_pkg::PH_IDLE);
      st.window_open      = (seq_phase == pcrs_pkg::PH_CHIRP) ||
                            (seq_phase == pcrs_pkg::PH_WAIT && !skip_next &&
                             due_ms <= regs.dismiss_window_ms);
      st.dismiss_accepted = accepted;
      st.phase            = seq_phase;
      return st;
   endfunction

   // ---------------------------------------------------------------- drivers

   // Offer one word after a random gap; predict its status once accepted
   task automatic send_word(input pcrs_pkg::kind_type kind, input logic [1:0] mode);
      int gap;
      gap = quiet ? 0 : $urandom_range(14);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_kind  <= kind;
      req_mode  <= mode;
      do @(posedge clock); while (!req_ready);
      pending_status.push_back(predict_status(kind, mode));
   endtask

   // Stop offering and wait until every predicted word has come back
   task automatic drain();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending_status.size() != 0);
      repeat (2) @(posedge clock);
   endtask

   task automatic put_reg(input pcrs_pkg::csr_index_type idx,
                          input logic [pcrs_pkg::CSR_DATA_W-1:0] value);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
   endtask

   // Write the whole bank; only called with the block idle
   task automatic program_regs(input pcrs_pkg::cfg_type c);
      put_reg(pcrs_pkg::CSR_INTERVAL,    c.interval_ms);
      put_reg(pcrs_pkg::CSR_OCC_SHORT,   24'(c.occurrences_short));
      put_reg(pcrs_pkg::CSR_OCC_LONG,    24'(c.occurrences_long));
      put_reg(pcrs_pkg::CSR_CHIRP_WIN,   c.chirp_window_ms);
      put_reg(pcrs_pkg::CSR_CHIRP_PER,   24'(c.chirp_period_ms));
      put_reg(pcrs_pkg::CSR_CHIRP_ON,    24'(c.chirp_on_ms));
      put_reg(pcrs_pkg::CSR_DISMISS_WIN, c.dismiss_window_ms);
      put_reg(pcrs_pkg::CSR_ACTIVE_LOW,  24'(c.pin_invert));
      csr_we <= 1'b0;
      regs = c;
   endtask

   // Small timings so that sequences run through many occurrences
   function automatic pcrs_pkg::cfg_type small_settings();
      pcrs_pkg::cfg_type c;
      c.interval_ms       = ($urandom_range(15) == 0) ? 24'd0 : 24'($urandom_range(14, 1));
      c.occurrences_short = 8'($urandom_range(4));
      c.occurrences_long  = 8'($urandom_range(6));
      c.chirp_window_ms   = 24'($urandom_range(20));
      c.chirp_period_ms   = 16'($urandom_range(8));
      c.chirp_on_ms       = 16'($urandom_range(9));
      c.dismiss_window_ms = 24'($urandom_range(12));
      c.pin_invert        = 1'($urandom_range(1));
      return c;
   endfunction

   // Mostly ticks with dismisses; starts are likely once the sequence has ended
   task automatic traffic_phase(input pcrs_pkg::cfg_type c, input int n_words);
      int                 r;
      pcrs_pkg::kind_type kind;
      logic [1:0]         mode;
      drain();
      program_regs(c);
      for (int i = 0; i < n_words; i++) begin
         r    = $urandom_range(99);
         mode = 2'($urandom_range(3));
         if ((seq_phase == pcrs_pkg::PH_IDLE && r < 40) || r < 3) begin
            kind = pcrs_pkg::KIND_START;
            if ($urandom_range(7) != 0)
               mode = $urandom_range(1) ? pcrs_pkg::MODE_LONG : pcrs_pkg::MODE_SHORT;
         end else if (r < 5) begin
            kind = pcrs_pkg::KIND_CANCEL;
         end else if (r < 22) begin
            kind = pcrs_pkg::KIND_DISMISS;
         end else begin
            kind = pcrs_pkg::KIND_TICK;
         end
         send_word(kind, mode);
      end
   endtask

   // ---------------------------------------------------------------- receiver

   initial begin : status_receiver
      int gap;
      while (reset) @(posedge clock);
      forever begin
         if (hold_off > 0) begin
            rsp_ready <= 1'b0;
            repeat (hold_off) @(posedge clock);
            hold_off = 0;
         end
         gap = quiet ? 0 : $urandom_range(14);
         if (gap > 0) begin
            rsp_ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
      end
   end

   // Compare each status word with the oldest prediction
   always @(posedge clock) begin : status_check
      pcrs_pkg::rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_status.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("status word arrived with nothing predicted");
         end else begin
            want = pending_status.pop_front();
            if (rsp_buzzer_pin       !== want.buzzer_pin      ||
                rsp_sequence_active  !== want.sequence_active ||
                rsp_window_open      !== want.window_open     ||
                rsp_dismiss_accepted !== want.dismiss_accepted ||
                rsp_phase            !== want.phase) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("status mismatch: expected pin %0b act %0b win %0b acc %0b ph %0d",
                           want.buzzer_pin, want.sequence_active, want.window_open,
                           want.dismiss_accepted, want.phase,
                           " / got pin %0b act %0b win %0b acc %0b ph %0d",
                           rsp_buzzer_pin, rsp_sequence_active, rsp_window_open,
                           rsp_dismiss_accepted, rsp_phase);
            end
         end
      end
   end

   // ---------------------------------------------------------------- tests

   // Reset settings: commands while idle, ignored modes, restart, cancel
   task automatic test_idle_commands();
      send_word(pcrs_pkg::KIND_CANCEL, MODE_OFF);
      send_word(pcrs_pkg::KIND_DISMISS, MODE_SPARE);
      send_word(pcrs_pkg::KIND_TICK, MODE_OFF);
      send_word(pcrs_pkg::KIND_START, MODE_OFF);
      send_word(pcrs_pkg::KIND_START, MODE_SPARE);
      send_word(pcrs_pkg::KIND_START, pcrs_pkg::MODE_SHORT);
      send_word(pcrs_pkg::KIND_DISMISS, MODE_OFF);     // far outside the window
      send_word(pcrs_pkg::KIND_TICK, MODE_OFF);
      send_word(pcrs_pkg::KIND_START, pcrs_pkg::MODE_LONG);      // restart while waiting
      send_word(pcrs_pkg::KIND_CANCEL, MODE_OFF);
   endtask

   // Zero occurrences still chirp once; pre-dismissal, repeat, and of the last one
   task automatic test_occurrence_flow();
      pcrs_pkg::cfg_type c;
      c = '{24'd4, 8'd0, 8'd2, 24'd3, 16'd2, 16'd1, 24'd1, 1'b1};
      drain();
      program_regs(c);
      send_word(pcrs_pkg::KIND_START, pcrs_pkg::MODE_SHORT);
      repeat (4) send_word(pcrs_pkg::KIND_TICK, MODE_OFF);
      send_word(pcrs_pkg::KIND_TICK, MODE_OFF);
      send_word(pcrs_pkg::KIND_DISMISS, MODE_OFF);     // ends the chirp and the sequence
      send_word(pcrs_pkg::KIND_START, pcrs_pkg::MODE_LONG);
      repeat (3) send_word(pcrs_pkg::KIND_TICK, MODE_OFF);
      send_word(pcrs_pkg::KIND_DISMISS, MODE_OFF);
      send_word(pcrs_pkg::KIND_DISMISS, MODE_OFF);     // accepted again, no effect
      send_word(pcrs_pkg::KIND_TICK, MODE_OFF);        // skipped silently
      repeat (3) send_word(pcrs_pkg::KIND_TICK, MODE_OFF);
      send_word(pcrs_pkg::KIND_DISMISS, MODE_OFF);     // last one: sequence ends
   endtask

   // Every register at its top value, then every one at its bottom value but the interval at 1
   task automatic test_extreme_settings();
      traffic_phase('{24'hFFFFFF, 8'hFF, 8'hFF, 24'hFFFFFF, 16'hFFFF, 16'hFFFF,
                      24'hFFFFFF, 1'b1}, 100);
      traffic_phase('{24'd1, 8'd0, 8'd0, 24'd0, 16'd0, 16'd0, 24'd0, 1'b0}, 100);
   endtask

   // Receiver stalls for a long stretch while words keep coming
   task automatic test_backpressure();
      pcrs_pkg::kind_type kind;
      drain();
      program_regs(small_settings());
      quiet    = 1'b1;
      hold_off = 200;
      send_word(pcrs_pkg::KIND_START, pcrs_pkg::MODE_LONG);
      for (int i = 0; i < 29; i++) begin
         if ($urandom_range(4) == 0) kind = pcrs_pkg::KIND_DISMISS;
         else kind = pcrs_pkg::KIND_TICK;
         send_word(kind, 2'($urandom_range(3)));
      end
      quiet = 1'b0;
   endtask

   // Random settings per phase; every fourth phase runs without idling
   task automatic test_random_traffic();
      pcrs_pkg::cfg_type c;
      for (int p = 0; p < 10; p++) begin
         c = small_settings();
         // chirp window longer than the interval
         if (p == 1) begin
            c.interval_ms     = 24'd3;
            c.chirp_window_ms = 24'd10;
         end
         quiet = (p % 4 == 3);
         traffic_phase(c, 110);
      end
      quiet = 1'b0;
   endtask

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      test_idle_commands();
      test_occurrence_flow();
      test_extreme_settings();
      test_backpressure();
      test_random_traffic();
      drain();
      if (mismatches == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

   // Watchdog, far above the slowest legal run
   initial begin
      #3000000;
      $display("== FAIL ==");
      $finish;
   end

endmodule
